### rtl/core/tswpf_pkg.sv
// ----------------------------------------------------------------------------
// tswpf_pkg
// Shared types, codes and helpers of the three-step walk pair finder.
// ----------------------------------------------------------------------------
package tswpf_pkg;

	localparam int NODES   = 32;
	localparam int IDX_W   = $clog2(NODES);
	localparam int FIELD_W = 5;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef logic [NODES-1:0] row_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_QUERY,
		KIND_ZERO,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t kind;
		idx_t  a;
		idx_t  b;
	} req_t;

	function automatic row_t onehot(input idx_t idx);
		return row_t'(1) << idx;
	endfunction

endpackage

### rtl/core/tswpf_front.sv
// ----------------------------------------------------------------------------
// tswpf_front
// Accepts requests, classifies them and queues all but unused codes and out-of-range adds.
// ----------------------------------------------------------------------------
module tswpf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [tswpf_pkg::FIELD_W-1:0] node_a,
	input  logic [tswpf_pkg::FIELD_W-1:0] node_b,
	output tswpf_pkg::req_t             head,
	output logic                        head_valid,
	input  logic                        pop
);
	import tswpf_pkg::*;

	req_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              accept;
	logic              keep;
	logic              in_range;
	req_t              cls;

	assign busy       = (count_q == QCNT_W'(QDEPTH));
	assign accept     = start && !busy;
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rptr_q];
	assign in_range   = (int'(node_a) < NODES) && (int'(node_b) < NODES);

	always_comb begin
		cls.a = idx_t'(node_a);
		cls.b = idx_t'(node_b);
		cls.kind = KIND_ZERO;
		keep = 1'b0;
		unique case (command)
			CMD_ADD: begin
				cls.kind = KIND_ADD;
				keep = in_range;
			end
			CMD_QUERY: begin
				// out of range or self pair answers zero without touching the matrix
				cls.kind = (in_range && node_a != node_b) ? KIND_QUERY : KIND_ZERO;
				keep = 1'b1;
			end
			CMD_CLEAR: begin
				cls.kind = KIND_CLEAR;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			q_mem[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (accept && keep) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(accept && keep) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty request queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop && !(accept && keep)) |=> $stable(count_q))
		else $error("queue fill changed without push or pop");
`endif

endmodule

### rtl/core/tswpf_back.sv
// ----------------------------------------------------------------------------
// tswpf_back
// Holds the adjacency matrix and carries out add, clear and query requests.
// ----------------------------------------------------------------------------
module tswpf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tswpf_pkg::req_t head,
	input  logic            head_valid,
	output logic            pop,
	output logic            done,
	output logic            related,
	output logic            direct
);
	import tswpf_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD_RD = 3'd1;
	localparam logic [2:0] ST_ADD_WA = 3'd2;
	localparam logic [2:0] ST_ADD_WB = 3'd3;
	localparam logic [2:0] ST_Q_RA   = 3'd4;
	localparam logic [2:0] ST_Q_RB   = 3'd5;
	localparam logic [2:0] ST_Q_DIR  = 3'd6;
	localparam logic [2:0] ST_SCAN   = 3'd7;
	localparam logic [2:0] ST_DONE   = 3'd0;

	logic [2:0] state_q;
	logic       fin_q;
	req_t       cur_q;
	row_t       mem [NODES];
	row_t       rd_q;
	logic       rd_vld_q;
	row_t       rdat;
	logic [NODES-1:0] vld_q;
	idx_t       rd_addr;
	logic       wr_en;
	idx_t       wr_addr;
	row_t       wr_data;
	row_t       rowa_q;
	row_t       rowb_q;
	row_t       reach_q;
	row_t       reach_fin;
	logic       hit_q;
	idx_t       x_q;
	logic       done_q;
	logic       related_q;
	logic       direct_q;

	assign pop     = (state_q == ST_IDLE) && !fin_q && head_valid;
	assign done    = done_q;
	assign related = related_q;
	assign direct  = direct_q;
	assign rdat    = rd_vld_q ? rd_q : '0;

	always_comb begin
		rd_addr = cur_q.a;
		wr_en   = 1'b0;
		wr_addr = cur_q.a;
		wr_data = rdat | onehot(cur_q.b);
		unique case (state_q)
			ST_ADD_WA: begin
				wr_en   = 1'b1;
				rd_addr = cur_q.b;
			end
			ST_ADD_WB: begin
				wr_en   = 1'b1;
				wr_addr = cur_q.b;
				wr_data = rdat | onehot(cur_q.a);
			end
			ST_Q_RB: begin
				rd_addr = cur_q.b;
			end
			ST_SCAN: begin
				rd_addr = x_q;
			end
			default: begin
				rd_addr = cur_q.a;
			end
		endcase
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// walk a-x-y-b: union of the neighbor rows of a, minus a itself, against row b
	assign reach_fin = reach_q | (hit_q ? rdat : '0);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_Q_RB: begin
				rowa_q <= rdat;
			end
			ST_Q_DIR: begin
				rowb_q  <= rdat;
				reach_q <= '0;
			end
			ST_SCAN: begin
				if (hit_q) begin
					reach_q <= reach_q | rdat;
				end
			end
			default: begin
				reach_q <= reach_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fin_q     <= 1'b0;
			cur_q     <= '0;
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			hit_q     <= 1'b0;
			x_q       <= '0;
			done_q    <= 1'b0;
			related_q <= 1'b0;
			direct_q  <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			related_q <= 1'b0;
			direct_q  <= 1'b0;
			rd_vld_q  <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (fin_q) begin
						// end of walk search
						fin_q     <= 1'b0;
						done_q    <= 1'b1;
						related_q <= |(reach_fin & ~onehot(cur_q.a) & rowb_q);
					end else if (head_valid) begin
						cur_q <= head;
						unique case (head.kind)
							KIND_ADD: begin
								state_q <= ST_ADD_RD;
							end
							KIND_QUERY: begin
								state_q <= ST_Q_RA;
							end
							KIND_ZERO: begin
								done_q <= 1'b1;
							end
							KIND_CLEAR: begin
								vld_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WA;
				end
				ST_ADD_WA: begin
					state_q <= ST_ADD_WB;
				end
				ST_ADD_WB: begin
					state_q <= ST_IDLE;
				end
				ST_Q_RA: begin
					state_q <= ST_Q_RB;
				end
				ST_Q_RB: begin
					state_q <= ST_Q_DIR;
				end
				ST_Q_DIR: begin
					if (rowa_q[cur_q.b]) begin
						done_q   <= 1'b1;
						direct_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						x_q     <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					hit_q <= rowa_q[x_q];
					x_q   <= x_q + 1'b1;
					if (x_q == idx_t'(NODES - 1)) begin
						state_q <= ST_DONE;
						fin_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_excl_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(related && direct))
		else $error("result both direct and related");
	a_flag_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(related || direct) |-> done)
		else $error("result flag without strobe");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("request taken while sequencer busy");
`endif

endmodule

### rtl/core/three_step_walk_pair_finder.sv
// A zero-answer query is answered straight from the request, an adjacent pair after reading
// both rows, otherwise after the walk search, which reads one adjacency row per node.
// The sequencer takes the next request only when it is done with the current one;
// a 2-entry request queue absorbs bursts.
// The result strobe lasts one cycle and cannot be stalled.
// Asynchronous active-low reset empties the queue and marks every matrix row as cleared.
// ----------------------------------------------------------------------------
// three_step_walk_pair_finder
// Adjacency matrix with edge add, clear and pair query for direct and 3-step links.
// ----------------------------------------------------------------------------
module three_step_walk_pair_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [tswpf_pkg::FIELD_W-1:0] node_a,
	input  logic [tswpf_pkg::FIELD_W-1:0] node_b,
	output logic                          done,
	output logic                          related,
	output logic                          direct
);
	import tswpf_pkg::*;

	req_t head;
	logic head_valid;
	logic pop;

	tswpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.node_a     (node_a),
		.node_b     (node_b),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	tswpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.done       (done),
		.related    (related),
		.direct     (direct)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, query and clear requests into the three-step walk pair finder,
// keeps its own copy of the adjacency matrix and checks every query answer.
// ----------------------------------------------------------------------------
module testbench;
	import tswpf_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 60;
	localparam int TARGET_REQUESTS = 1200;

	typedef struct {
		bit related;
		bit direct;
	} answer_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [FIELD_W-1:0] node_a;
	logic [FIELD_W-1:0] node_b;
	logic done;
	logic related;
	logic direct;

	row_t links [NODES];
	answer_t pending_answers [$];
	int errors;
	int requests_sent;
	int burst_left;
	bit use_gaps;
	int quiet_cycles;

	three_step_walk_pair_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.node_a(node_a),
		.node_b(node_b),
		.done(done),
		.related(related),
		.direct(direct)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// some x adjacent to a, some y != a adjacent to x, and y adjacent to b
	function automatic bit walk_found(int a, int b);
		row_t second_hop;
		second_hop = '0;
		for (int x = 0; x < NODES; x++)
			if (links[a][x])
				second_hop |= links[x];
		second_hop[a] = 1'b0;
		for (int y = 0; y < NODES; y++)
			if (second_hop[y] && links[y][b])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic answer_t answer_query(int a, int b);
		answer_t ans;
		ans.related = 1'b0;
		ans.direct = 1'b0;
		if (a < NODES && b < NODES && a != b) begin
			if (links[a][b])
				ans.direct = 1'b1;
			else if (walk_found(a, b))
				ans.related = 1'b1;
		end
		return ans;
	endfunction

	// answer check first, then the request accepted at this edge
	always @(posedge clk) begin
		answer_t exp_ans;
		int a;
		int b;
		if (arst_n) begin
			if (done) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: answer with none expected: related %0b direct %0b",
						$time, related, direct);
					errors++;
				end else begin
					exp_ans = pending_answers.pop_front();
					if (related !== exp_ans.related) begin
						$display("%0t: related mismatch: expected %0b actual %0b",
							$time, exp_ans.related, related);
						errors++;
					end
					if (direct !== exp_ans.direct) begin
						$display("%0t: direct mismatch: expected %0b actual %0b",
							$time, exp_ans.direct, direct);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				a = int'(node_a);
				b = int'(node_b);
				case (command)
					CMD_ADD: begin
						if (a < NODES && b < NODES) begin
							links[a][b] = 1'b1;
							links[b][a] = 1'b1;
						end
					end
					CMD_QUERY: pending_answers.insert(pending_answers.size(),
						answer_query(a, b));
					CMD_CLEAR: begin
						for (int i = 0; i < NODES; i++)
							links[i] = '0;
					end
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(logic [1:0] cmd, int a, int b);
		if (use_gaps) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(1, 12)) begin
					@(negedge clk);
					start <= 1'b0;
				end
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		node_a <= a[FIELD_W-1:0];
		node_b <= b[FIELD_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (cmd != CMD_UNUSED)
			requests_sent++;
	endtask

	task automatic wait_for_answers();
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_request(CMD_QUERY, 0, 31);
		send_request(CMD_ADD, 0, 31);
		send_request(CMD_QUERY, 0, 31);
		send_request(CMD_QUERY, 31, 0);
		// self-edge stored, but a node queried with itself answers zero
		send_request(CMD_ADD, 5, 5);
		send_request(CMD_QUERY, 5, 5);
		// unused code must leave the matrix alone
		send_request(CMD_UNUSED, 7, 9);
		send_request(CMD_QUERY, 7, 9);
		// chain 1-2-3-4
		send_request(CMD_ADD, 1, 2);
		send_request(CMD_ADD, 2, 3);
		send_request(CMD_ADD, 3, 4);
		send_request(CMD_QUERY, 1, 4);
		send_request(CMD_QUERY, 1, 3);
		send_request(CMD_QUERY, 4, 1);
		// walk through a self-loop on the first node
		send_request(CMD_ADD, 20, 20);
		send_request(CMD_ADD, 20, 21);
		send_request(CMD_ADD, 21, 22);
		send_request(CMD_QUERY, 20, 22);
		send_request(CMD_QUERY, 20, 21);
		wait_for_answers();
		send_request(CMD_CLEAR, 31, 31);
		send_request(CMD_QUERY, 1, 4);
		send_request(CMD_QUERY, 0, 31);
		send_request(CMD_CLEAR, 0, 0);
		send_request(CMD_QUERY, 31, 31);
		wait_for_answers();
	endtask

	task automatic test_random_graphs();
		int span;
		int base;
		while (requests_sent < TARGET_REQUESTS) begin
			span = $urandom_range(4, 10);
			base = $urandom_range(0, NODES - span);
			send_request(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
			repeat ($urandom_range(2, 12))
				send_request(CMD_ADD, base + $urandom_range(0, span - 1),
					base + $urandom_range(0, span - 1));
			repeat ($urandom_range(5, 15)) begin
				case ($urandom_range(0, 9))
					0: send_request(CMD_QUERY, $urandom_range(0, 31), $urandom_range(0, 31));
					1: send_request(2'($urandom_range(0, 3)), $urandom_range(0, 31),
						$urandom_range(0, 31));
					default: send_request(CMD_QUERY, base + $urandom_range(0, span - 1),
						base + $urandom_range(0, span - 1));
				endcase
			end
			if ($urandom_range(0, 3) == 0)
				wait_for_answers();
		end
	endtask

	task automatic test_back_to_back();
		use_gaps = 1'b0;
		send_request(CMD_CLEAR, 0, 0);
		for (int i = 0; i < 8; i++)
			send_request(CMD_ADD, i, i + 1);
		for (int i = 0; i < 16; i++)
			send_request(CMD_QUERY, $urandom_range(0, 9), $urandom_range(0, 9));
		use_gaps = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ADD;
		node_a = '0;
		node_b = '0;
		errors = 0;
		requests_sent = 0;
		burst_left = 0;
		use_gaps = 1'b1;
		quiet_cycles = 0;
		for (int i = 0; i < NODES; i++)
			links[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_back_to_back();
		test_random_graphs();
		test_back_to_back();

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/tswpf_pkg.sv
rtl/core/tswpf_front.sv
rtl/core/tswpf_back.sv
rtl/core/three_step_walk_pair_finder.sv
dv/testbench.sv
